/* hw/rtl/disk_arm_scheduler_fcfs_sstf_assert.svh */
// assertion macros for the disk arm scheduler
`ifndef DISK_ARM_SCHEDULER_FCFS_SSTF_ASSERT_SVH
`define DISK_ARM_SCHEDULER_FCFS_SSTF_ASSERT_SVH

// same-cycle implication
`define DASF_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dasf: same-cycle check failed");

// next-cycle implication
`define DASF_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dasf: next-cycle check failed");

`endif

/* hw/rtl/dasf_pkg.sv */
// shared types and constants of the disk arm scheduler
package dasf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TRACK_BITS  = 16;

    localparam int ID_W      = 16;
    localparam int FIELD_W   = 16;
    localparam int TIME_W    = 32;
    localparam int MOVE_W    = 32;
    localparam int KIND_W    = 2;

    localparam int Q_IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam int EVT_DEPTH = QUEUE_DEPTH + 2;
    localparam int EVT_IDX_W = $clog2(EVT_DEPTH);
    localparam int EVT_CNT_W = $clog2(EVT_DEPTH + 1);

    typedef logic [TRACK_BITS-1:0] track_t;
    typedef logic [ID_W-1:0]       req_id_t;
    typedef logic [TIME_W-1:0]     time_t;
    typedef logic [MOVE_W-1:0]     move_t;

    typedef enum logic [KIND_W-1:0] {
        EVT_ISSUE  = 2'd0,
        EVT_FINISH = 2'd1,
        EVT_STATUS = 2'd2,
        EVT_REJECT = 2'd3
    } evt_kind_t;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_TICK = 1'b1
    } command_t;

    typedef enum logic {
        POLICY_FCFS = 1'b0,
        POLICY_SSTF = 1'b1
    } policy_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PICK,
        ST_SCAN,
        ST_TAKE,
        ST_STATUS,
        ST_DRAIN_RD,
        ST_DRAIN_WR
    } state_t;

    typedef struct packed {
        evt_kind_t kind;
        req_id_t   id;
        track_t    track;
    } evt_entry_t;

    typedef struct packed {
        logic latch_in;
        logic append;
        logic reject;
        logic finish_cur;
        logic pick_init;
        logic scan_step;
        logic take;
        logic status;
        logic drain_rd;
        logic drain_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic queue_full;
        logic queue_empty;
        logic cur_valid;
        logic cur_on_head;
        logic sstf;
        logic scan_done;
        logic drain_last;
        logic out_free;
    } dp_status_t;

endpackage

/* hw/rtl/dasf_if.sv */
// channel interfaces of the disk arm scheduler
interface dasf_item_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [dasf_pkg::ID_W-1:0]    request_id;
    logic [dasf_pkg::FIELD_W-1:0] request_track;

    modport source (output valid, command, request_id, request_track, input ready);
    modport sink   (input valid, command, request_id, request_track, output ready);
endinterface

interface dasf_result_if;
    logic                         valid;
    logic                         ready;
    logic [dasf_pkg::KIND_W-1:0]  event_kind;
    logic [dasf_pkg::ID_W-1:0]    event_id;
    logic [dasf_pkg::FIELD_W-1:0] event_track;
    logic [dasf_pkg::TIME_W-1:0]  event_time;
    logic [dasf_pkg::FIELD_W-1:0] head_track;
    logic [dasf_pkg::MOVE_W-1:0]  movement_total;
    logic                         arm_busy;
    logic                         last_of_run;

    modport source (output valid, event_kind, event_id, event_track, event_time,
                    head_track, movement_total, arm_busy, last_of_run, input ready);
    modport sink   (input valid, event_kind, event_id, event_track, event_time,
                    head_track, movement_total, arm_busy, last_of_run, output ready);
endinterface

interface dasf_cfg_if;
    logic valid;
    logic ready;
    logic policy_mode;

    modport source (output valid, policy_mode, input ready);
    modport sink   (input valid, policy_mode, output ready);
endinterface

/* hw/rtl/dasf_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module dasf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/dasf_ctrl.sv */
// sequencer of the disk arm scheduler
module dasf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  dasf_pkg::dp_status_t status,
    output logic                 item_ready,
    output dasf_pkg::ctrl_cmd_t  cmd
);

    dasf_pkg::state_t state_reg;
    dasf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dasf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            dasf_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = dasf_pkg::ST_DISPATCH;
                end
            end
            dasf_pkg::ST_DISPATCH:
            begin
                if (!status.is_tick)
                begin
                    if (status.queue_full)
                    begin
                        cmd.reject = 1'b1;
                        state_next = dasf_pkg::ST_DRAIN_RD;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        state_next = dasf_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.finish_cur = status.cur_valid && status.cur_on_head;
                    state_next     = dasf_pkg::ST_PICK;
                end
            end
            dasf_pkg::ST_PICK:
            begin
                if (status.cur_valid || status.queue_empty)
                begin
                    state_next = dasf_pkg::ST_STATUS;
                end
                else
                begin
                    cmd.pick_init = 1'b1;
                    state_next    = status.sstf ? dasf_pkg::ST_SCAN : dasf_pkg::ST_TAKE;
                end
            end
            dasf_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = dasf_pkg::ST_TAKE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            dasf_pkg::ST_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = dasf_pkg::ST_PICK;
            end
            dasf_pkg::ST_STATUS:
            begin
                cmd.status = 1'b1;
                state_next = dasf_pkg::ST_DRAIN_RD;
            end
            dasf_pkg::ST_DRAIN_RD:
            begin
                cmd.drain_rd = 1'b1;
                state_next   = dasf_pkg::ST_DRAIN_WR;
            end
            dasf_pkg::ST_DRAIN_WR:
            begin
                if (status.out_free)
                begin
                    cmd.drain_load = 1'b1;
                    state_next     = status.drain_last ? dasf_pkg::ST_IDLE
                                                       : dasf_pkg::ST_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = dasf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/dasf_dp.sv */
// datapath of the disk arm scheduler: queue, arm state, event buffer, output register
module dasf_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dasf_pkg::ctrl_cmd_t          cmd,
    output dasf_pkg::dp_status_t         status,
    input  logic                         command,
    input  logic [dasf_pkg::ID_W-1:0]    request_id,
    input  logic [dasf_pkg::FIELD_W-1:0] request_track,
    input  logic                         cfg_valid,
    input  logic                         cfg_policy,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dasf_pkg::KIND_W-1:0]  out_kind,
    output logic [dasf_pkg::ID_W-1:0]    out_id,
    output logic [dasf_pkg::FIELD_W-1:0] out_track,
    output logic [dasf_pkg::TIME_W-1:0]  out_time,
    output logic [dasf_pkg::FIELD_W-1:0] out_head,
    output logic [dasf_pkg::MOVE_W-1:0]  out_move,
    output logic                         out_busy,
    output logic                         out_last
);

    function automatic dasf_pkg::track_t to_track(input logic [dasf_pkg::FIELD_W-1:0] x);
        logic [47:0] w;
        w = {32'd0, x};
        return w[dasf_pkg::TRACK_BITS-1:0];
    endfunction

    function automatic logic [dasf_pkg::FIELD_W-1:0] to_field(input dasf_pkg::track_t t);
        logic [47:0] w;
        w = 48'(t);
        return w[dasf_pkg::FIELD_W-1:0];
    endfunction

    function automatic dasf_pkg::track_t track_dist(input dasf_pkg::track_t a,
                                                    input dasf_pkg::track_t b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // latched transaction
    dasf_pkg::command_t in_cmd_reg;
    dasf_pkg::req_id_t  in_id_reg;
    dasf_pkg::track_t   in_track_reg;
    dasf_pkg::time_t    now_reg;

    // pending queue in arrival order
    dasf_pkg::req_id_t  q_id_reg    [dasf_pkg::QUEUE_DEPTH];
    dasf_pkg::track_t   q_track_reg [dasf_pkg::QUEUE_DEPTH];
    logic [dasf_pkg::Q_CNT_W-1:0] q_cnt_reg;

    // arm state
    dasf_pkg::policy_t  policy_reg;
    logic               cur_valid_reg;
    dasf_pkg::req_id_t  cur_id_reg;
    dasf_pkg::track_t   cur_track_reg;
    dasf_pkg::track_t   head_reg;
    dasf_pkg::time_t    tick_reg;
    dasf_pkg::move_t    move_reg;

    // selection
    logic [dasf_pkg::Q_IDX_W-1:0] best_idx_reg;
    dasf_pkg::req_id_t            best_id_reg;
    dasf_pkg::track_t             best_track_reg;
    dasf_pkg::track_t             best_dist_reg;
    logic [dasf_pkg::Q_CNT_W-1:0] scan_cnt_reg;

    // event buffer pointers
    logic [dasf_pkg::EVT_CNT_W-1:0] evt_cnt_reg;
    logic [dasf_pkg::EVT_CNT_W-1:0] rd_ptr_reg;

    // output register
    logic                          out_valid_reg;
    dasf_pkg::evt_kind_t           out_kind_reg;
    dasf_pkg::req_id_t             out_id_reg;
    logic [dasf_pkg::FIELD_W-1:0]  out_track_reg;
    dasf_pkg::time_t               out_time_reg;
    logic [dasf_pkg::FIELD_W-1:0]  out_head_reg;
    dasf_pkg::move_t               out_move_reg;
    logic                          out_busy_reg;
    logic                          out_last_reg;

    logic [dasf_pkg::Q_IDX_W-1:0] scan_idx;
    dasf_pkg::track_t             scan_track;
    dasf_pkg::track_t             scan_dist;
    logic                         take_on_head;
    logic                         evt_wr;
    dasf_pkg::evt_entry_t         evt_wr_data;
    dasf_pkg::evt_entry_t         evt_rd_data;
    logic                         drain_last;

    assign scan_idx     = scan_cnt_reg[dasf_pkg::Q_IDX_W-1:0];
    assign scan_track   = q_track_reg[scan_idx];
    assign scan_dist    = track_dist(scan_track, head_reg);
    assign take_on_head = (best_track_reg == head_reg);
    assign drain_last   = (dasf_pkg::EVT_CNT_W'(rd_ptr_reg + 1'b1) == evt_cnt_reg);

    always_comb
    begin
        evt_wr      = cmd.reject || cmd.finish_cur || cmd.take || cmd.status;
        evt_wr_data = '{kind: dasf_pkg::EVT_STATUS, id: '0, track: '0};
        if (cmd.reject)
        begin
            evt_wr_data = '{kind: dasf_pkg::EVT_REJECT, id: in_id_reg, track: in_track_reg};
        end
        else if (cmd.finish_cur)
        begin
            evt_wr_data = '{kind: dasf_pkg::EVT_FINISH, id: cur_id_reg, track: cur_track_reg};
        end
        else if (cmd.take)
        begin
            evt_wr_data = '{kind:  take_on_head ? dasf_pkg::EVT_FINISH : dasf_pkg::EVT_ISSUE,
                            id:    best_id_reg,
                            track: best_track_reg};
        end
        else if (cur_valid_reg)
        begin
            evt_wr_data = '{kind: dasf_pkg::EVT_STATUS, id: cur_id_reg, track: cur_track_reg};
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_cmd_reg   <= dasf_pkg::command_t'(command);
            in_id_reg    <= request_id;
            in_track_reg <= to_track(request_track);
            now_reg      <= tick_reg;
        end

        if (cmd.append)
        begin
            q_id_reg[q_cnt_reg[dasf_pkg::Q_IDX_W-1:0]]    <= in_id_reg;
            q_track_reg[q_cnt_reg[dasf_pkg::Q_IDX_W-1:0]] <= in_track_reg;
        end
        else if (cmd.take)
        begin
            for (int i = 0; i < dasf_pkg::QUEUE_DEPTH - 1; i++)
            begin
                if (dasf_pkg::Q_IDX_W'(i) >= best_idx_reg)
                begin
                    q_id_reg[i]    <= q_id_reg[i + 1];
                    q_track_reg[i] <= q_track_reg[i + 1];
                end
            end
        end

        if (cmd.pick_init)
        begin
            best_idx_reg   <= '0;
            best_id_reg    <= q_id_reg[0];
            best_track_reg <= q_track_reg[0];
            best_dist_reg  <= track_dist(q_track_reg[0], head_reg);
        end
        else if (cmd.scan_step && (scan_dist < best_dist_reg))
        begin
            best_idx_reg   <= scan_idx;
            best_id_reg    <= q_id_reg[scan_idx];
            best_track_reg <= scan_track;
            best_dist_reg  <= scan_dist;
        end

        if (cmd.drain_load)
        begin
            out_kind_reg  <= evt_rd_data.kind;
            out_id_reg    <= evt_rd_data.id;
            out_track_reg <= to_field(evt_rd_data.track);
            out_time_reg  <= now_reg;
            out_head_reg  <= to_field(head_reg);
            out_move_reg  <= move_reg;
            out_busy_reg  <= cur_valid_reg;
            out_last_reg  <= drain_last;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= dasf_pkg::POLICY_FCFS;
            q_cnt_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_id_reg    <= '0;
            cur_track_reg <= '0;
            head_reg      <= '0;
            tick_reg      <= dasf_pkg::TIME_W'(1);
            move_reg      <= '0;
            scan_cnt_reg  <= '0;
            evt_cnt_reg   <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                policy_reg <= dasf_pkg::policy_t'(cfg_policy);
            end

            if (cmd.append)
            begin
                q_cnt_reg <= q_cnt_reg + 1'b1;
            end
            else if (cmd.take)
            begin
                q_cnt_reg <= q_cnt_reg - 1'b1;
            end

            if (cmd.finish_cur)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (cmd.take && !take_on_head)
            begin
                cur_valid_reg <= 1'b1;
                cur_id_reg    <= best_id_reg;
                cur_track_reg <= best_track_reg;
            end

            if (cmd.status)
            begin
                tick_reg <= now_reg + 1'b1;
                if (cur_valid_reg)
                begin
                    head_reg <= (head_reg > cur_track_reg) ? head_reg - 1'b1 : head_reg + 1'b1;
                    if (move_reg != '1)
                    begin
                        move_reg <= move_reg + 1'b1;
                    end
                end
            end

            if (cmd.pick_init)
            begin
                scan_cnt_reg <= dasf_pkg::Q_CNT_W'(1);
            end
            else if (cmd.scan_step)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end

            if (cmd.latch_in)
            begin
                evt_cnt_reg <= '0;
                rd_ptr_reg  <= '0;
            end
            else
            begin
                if (evt_wr)
                begin
                    evt_cnt_reg <= evt_cnt_reg + 1'b1;
                end
                if (cmd.drain_load)
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end

            if (cmd.drain_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    dasf_ram #(
        .WIDTH ($bits(dasf_pkg::evt_entry_t)),
        .DEPTH (dasf_pkg::EVT_DEPTH)
    ) u_evt_buf (
        .clk     (clk),
        .wr_en   (evt_wr),
        .wr_addr (evt_cnt_reg[dasf_pkg::EVT_IDX_W-1:0]),
        .wr_data (evt_wr_data),
        .rd_en   (cmd.drain_rd),
        .rd_addr (rd_ptr_reg[dasf_pkg::EVT_IDX_W-1:0]),
        .rd_data (evt_rd_data)
    );

    always_comb
    begin
        status.is_tick     = (in_cmd_reg == dasf_pkg::CMD_TICK);
        status.queue_full  = (q_cnt_reg == dasf_pkg::Q_CNT_W'(dasf_pkg::QUEUE_DEPTH));
        status.queue_empty = (q_cnt_reg == '0);
        status.cur_valid   = cur_valid_reg;
        status.cur_on_head = (cur_track_reg == head_reg);
        status.sstf        = (policy_reg == dasf_pkg::POLICY_SSTF);
        status.scan_done   = (scan_cnt_reg >= q_cnt_reg);
        status.drain_last  = drain_last;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_id    = out_id_reg;
    assign out_track = out_track_reg;
    assign out_time  = out_time_reg;
    assign out_head  = out_head_reg;
    assign out_move  = out_move_reg;
    assign out_busy  = out_busy_reg;
    assign out_last  = out_last_reg;

endmodule

/* hw/rtl/disk_arm_scheduler_fcfs_sstf.sv */
// top level of the disk arm scheduler
//
//   channel  | dir | transaction
//   ---------+-----+------------------------------------------------
//   item     | in  | add request or advance one tick
//   result   | out | issue, finish, tick status or reject event
//   cfg      | in  | policy_mode write, accepted in any cycle
//
// add: accept, then dispatch; rejected add adds one result drain
// tick: accept, dispatch, pick and status, plus, per picked request, a pick and a take under fcfs
//   or a pick, a scan and a take under sstf (queue scanned one entry a cycle), plus a read and
//   a load per result from the event buffer
// next transaction is taken once the last result sits in the output register
// a stalled result holds the event buffer drain; reset is asynchronous, no clearing pass
`include "disk_arm_scheduler_fcfs_sstf_assert.svh"

module disk_arm_scheduler_fcfs_sstf (
    input  logic             clk,
    input  logic             rst_n,
    dasf_item_if.sink        item,
    dasf_result_if.source    result,
    dasf_cfg_if.sink         cfg
);

    dasf_pkg::ctrl_cmd_t  cmd;
    dasf_pkg::dp_status_t status;
    logic                 item_ready;

    assign item.ready = item_ready;
    assign cfg.ready  = 1'b1;

    dasf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .status     (status),
        .item_ready (item_ready),
        .cmd        (cmd)
    );

    dasf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .command       (item.command),
        .request_id    (item.request_id),
        .request_track (item.request_track),
        .cfg_valid     (cfg.valid),
        .cfg_policy    (cfg.policy_mode),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .out_kind      (result.event_kind),
        .out_id        (result.event_id),
        .out_track     (result.event_track),
        .out_time      (result.event_time),
        .out_head      (result.head_track),
        .out_move      (result.movement_total),
        .out_busy      (result.arm_busy),
        .out_last      (result.last_of_run)
    );

    `DASF_ASSERT_NXT(a_accept_then_busy, clk, rst_n, item.valid && item.ready, !item.ready)
    `DASF_ASSERT_NXT(a_drain_fills_output, clk, rst_n, cmd.drain_load, result.valid)
    `DASF_ASSERT_IMP(a_mid_run_not_ready, clk, rst_n, result.valid && result.ready && !result.last_of_run, !item.ready)

endmodule
